// ===== rtl/nra_pkg.sv =====
package nra_pkg;

    // Field widths fixed by the interface.
    localparam int XY_W       = 32;
    localparam int ID_W       = 9;
    localparam int RAD_W      = 31;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Internal datapath widths: the squared distance, its root and the root remainder.
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int ROOT_REM_W = 35;

    localparam int MAX_AGENTS_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_SELF_X      = cfg_idx_t'(0);
    localparam cfg_idx_t REG_SELF_Y      = cfg_idx_t'(1);
    localparam cfg_idx_t REG_COMM_RADIUS = cfg_idx_t'(2);
    localparam cfg_idx_t REG_SELF_ID     = cfg_idx_t'(3);

endpackage

// ===== rtl/nra_comp.sv =====
module nra_comp
    import nra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [RAD_W-1:0]            mag,
    input  logic                        neg,
    input  logic [ROOT_W-1:0]           dist_val,
    output logic                        done,
    output logic signed [FRAC_BITS:0]   contrib
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int REM_W = ROOT_W + 2;
    localparam logic [ROOT_W:0] FX_ONE = (ROOT_W + 1)'(1) << FRAC_BITS;

    logic                   active_reg, active_next;
    logic                   phase_reg, phase_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [ROOT_W:0]        div_reg, div_next;
    logic [FRAC_BITS:0]     quo_reg, quo_next;
    logic                   neg_reg, neg_next;
    logic                   done_reg, done_next;
    logic [FRAC_BITS:0]     contrib_reg, contrib_next;

    logic                   ge;
    logic [REM_W-1:0]       rem_sub;
    logic [FRAC_BITS:0]     quo_shift;

    // One restoring division step per cycle. The first pass forms the unit component
    // (mag << F) / distance, the second pass divides it by (distance + 1.0).
    assign ge        = rem_reg >= {1'b0, div_reg};
    assign rem_sub   = ge ? (rem_reg - {1'b0, div_reg}) : rem_reg;
    assign quo_shift = {quo_reg[FRAC_BITS-1:0], ge};

    always_comb
    begin
        active_next  = active_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        done_next    = 1'b0;
        contrib_next = contrib_reg;
        if (start)
        begin
            active_next = 1'b1;
            phase_next  = 1'b0;
            cnt_next    = CNT_W'(FRAC_BITS);
            rem_next    = REM_W'(mag);
            div_next    = {1'b0, dist_val};
            quo_next    = '0;
            neg_next    = neg;
        end
        else if (active_reg)
        begin
            if (cnt_reg == '0)
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    cnt_next   = CNT_W'(FRAC_BITS - 1);
                    rem_next   = REM_W'({quo_shift, 1'b0});
                    div_next   = div_reg + FX_ONE;
                    quo_next   = '0;
                end
                else
                begin
                    active_next  = 1'b0;
                    done_next    = 1'b1;
                    contrib_next = neg_reg ? (~quo_shift + 1'b1) : quo_shift;
                end
            end
            else
            begin
                rem_next = {rem_sub[REM_W-2:0], 1'b0};
                quo_next = quo_shift;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        contrib_reg <= contrib_next;
    end

    assign done    = done_reg;
    assign contrib = contrib_reg;

endmodule

// ===== rtl/neighbor_repulsion_accumulator_top.sv =====
// Repulsion accumulator: one item per agent (start while busy is low), results only on
// the item marked last_agent, presented for exactly one cycle with done; the receiver
// cannot stall, so done must be sampled when it appears. An item skipped for its
// identifier or for |dx| or |dy| beyond the radius passes only the magnitude check and
// the closing step. Any other item goes through the bit-serial square sum, the two-bit-per-
// cycle square root, the range check and the closing step, and one that contributes also
// passes the shift-subtract dividers before the closing step. Registers are written
// through the cfg channel, which is always ready; the user must write them only while no
// item is in work, and the block itself does not enforce it.
module neighbor_repulsion_accumulator_top
    import nra_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [ID_W-1:0]             other_id,
    input  logic signed [XY_W-1:0]      other_x,
    input  logic signed [XY_W-1:0]      other_y,
    input  logic                        last_agent,
    output logic                        done,
    output logic signed [XY_W-1:0]      drive_x,
    output logic signed [XY_W-1:0]      drive_y,
    output logic [COUNT_W-1:0]          neighbors_used,
    output logic                        coincident_seen
);

    localparam int COUNT_CAP = (MAX_AGENTS < 511) ? MAX_AGENTS : 511;
    localparam int STEP_W    = 5;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAG   = 3'd1;
    localparam logic [2:0] ST_SQR   = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    // Configuration registers.
    logic [XY_W-1:0]        self_x_reg;
    logic [XY_W-1:0]        self_y_reg;
    logic [RAD_W-1:0]       radius_reg;
    logic [ID_W-1:0]        self_id_reg;

    logic [2:0]             state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   last_reg, last_next;
    logic                   id_hit_reg, id_hit_next;
    logic [XY_W-1:0]        ax_reg, ax_next;
    logic [XY_W-1:0]        ay_reg, ay_next;
    logic                   negx_reg, negx_next;
    logic                   negy_reg, negy_next;
    logic [RAD_W-1:0]       qx_reg, qx_next;
    logic [RAD_W-1:0]       qy_reg, qy_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [ROOT_REM_W-1:0]  rrem_reg, rrem_next;

    logic signed [XY_W-1:0] sum_x_reg, sum_x_next;
    logic signed [XY_W-1:0] sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0]     used_reg, used_next;
    logic                   coin_reg, coin_next;

    logic                   done_reg, done_next;
    logic [XY_W-1:0]        drive_x_reg, drive_x_next;
    logic [XY_W-1:0]        drive_y_reg, drive_y_next;
    logic [COUNT_W-1:0]     nused_reg, nused_next;
    logic                   coin_out_reg, coin_out_next;

    logic                   accept;
    logic signed [XY_W:0]   dx, dy;
    logic [XY_W:0]          dx_abs, dy_abs;
    logic [SQ_W-1:0]        sq_addx, sq_addy;
    logic [ROOT_REM_W-1:0]  rrem_sh, rtrial;
    logic                   rge;
    logic                   in_range;

    logic                   comp_start;
    logic                   cx_done, cy_done;
    logic signed [FRAC_BITS:0] cx, cy;
    logic signed [XY_W:0]   sum_x_wide, sum_y_wide;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_x_reg  <= '0;
            self_y_reg  <= '0;
            radius_reg  <= '0;
            self_id_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SELF_X:      self_x_reg  <= cfg_data[XY_W-1:0];
                REG_SELF_Y:      self_y_reg  <= cfg_data[XY_W-1:0];
                REG_COMM_RADIUS: radius_reg  <= cfg_data[RAD_W-1:0];
                REG_SELF_ID:     self_id_reg <= cfg_data[ID_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign dx     = $signed({self_x_reg[XY_W-1], self_x_reg}) - $signed({other_x[XY_W-1], other_x});
    assign dy     = $signed({self_y_reg[XY_W-1], self_y_reg}) - $signed({other_y[XY_W-1], other_y});
    assign dx_abs = dx[XY_W] ? (~dx + 1'b1) : dx;
    assign dy_abs = dy[XY_W] ? (~dy + 1'b1) : dy;

    // Square sum, most significant multiplier bit first.
    assign sq_addx = qx_reg[RAD_W-1] ? SQ_W'(ax_reg[RAD_W-1:0]) : '0;
    assign sq_addy = qy_reg[RAD_W-1] ? SQ_W'(ay_reg[RAD_W-1:0]) : '0;

    // Square root, two bits of the radicand per cycle.
    assign rrem_sh = {rrem_reg[ROOT_REM_W-3:0], sq_reg[SQ_W-1:SQ_W-2]};
    assign rtrial  = ROOT_REM_W'({root_reg, 2'b01});
    assign rge     = rrem_sh >= rtrial;

    // The squared distance is within r*r exactly when the root is below r, or equals r
    // with nothing left over.
    assign in_range = (root_reg < ROOT_W'(radius_reg)) ||
                      ((root_reg == ROOT_W'(radius_reg)) && (rrem_reg == '0));

    assign comp_start = (state_reg == ST_RANGE) && in_range && (root_reg != '0);

    nra_comp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_comp_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (comp_start),
        .mag      (ax_reg[RAD_W-1:0]),
        .neg      (negx_reg),
        .dist_val (root_reg),
        .done     (cx_done),
        .contrib  (cx)
    );

    nra_comp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_comp_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (comp_start),
        .mag      (ay_reg[RAD_W-1:0]),
        .neg      (negy_reg),
        .dist_val (root_reg),
        .done     (cy_done),
        .contrib  (cy)
    );

    assign sum_x_wide = $signed({sum_x_reg[XY_W-1], sum_x_reg}) + (XY_W + 1)'(cx);
    assign sum_y_wide = $signed({sum_y_reg[XY_W-1], sum_y_reg}) + (XY_W + 1)'(cy);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        last_next     = last_reg;
        id_hit_next   = id_hit_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        negx_next     = negx_reg;
        negy_next     = negy_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        sq_next       = sq_reg;
        root_next     = root_reg;
        rrem_next     = rrem_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        used_next     = used_reg;
        coin_next     = coin_reg;
        done_next     = 1'b0;
        drive_x_next  = drive_x_reg;
        drive_y_next  = drive_y_reg;
        nused_next    = nused_reg;
        coin_out_next = coin_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next   = last_agent;
                    id_hit_next = (other_id == self_id_reg);
                    ax_next     = dx_abs[XY_W-1:0];
                    ay_next     = dy_abs[XY_W-1:0];
                    negx_next   = dx[XY_W];
                    negy_next   = dy[XY_W];
                    state_next  = ST_MAG;
                end
            end
            ST_MAG:
            begin
                if (id_hit_reg || (ax_reg > XY_W'(radius_reg)) || (ay_reg > XY_W'(radius_reg)))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    qx_next    = ax_reg[RAD_W-1:0];
                    qy_next    = ay_reg[RAD_W-1:0];
                    sq_next    = '0;
                    step_next  = STEP_W'(RAD_W - 1);
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                sq_next = {sq_reg[SQ_W-2:0], 1'b0} + sq_addx + sq_addy;
                qx_next = {qx_reg[RAD_W-2:0], 1'b0};
                qy_next = {qy_reg[RAD_W-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    root_next  = '0;
                    rrem_next  = '0;
                    step_next  = STEP_W'(ROOT_W - 1);
                    state_next = ST_ROOT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_ROOT:
            begin
                rrem_next = rge ? (rrem_sh - rtrial) : rrem_sh;
                root_next = {root_reg[ROOT_W-2:0], rge};
                sq_next   = {sq_reg[SQ_W-3:0], 2'b00};
                if (step_reg == '0)
                begin
                    state_next = ST_RANGE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_RANGE:
            begin
                if (!in_range)
                begin
                    state_next = ST_FIN;
                end
                else if (root_reg == '0)
                begin
                    // Same position as ours: no direction, only flagged.
                    coin_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cx_done)
                begin
                    if (sum_x_wide[XY_W] != sum_x_wide[XY_W-1])
                    begin
                        sum_x_next = sum_x_wide[XY_W] ? {1'b1, {(XY_W-1){1'b0}}}
                                                      : {1'b0, {(XY_W-1){1'b1}}};
                    end
                    else
                    begin
                        sum_x_next = sum_x_wide[XY_W-1:0];
                    end
                    if (sum_y_wide[XY_W] != sum_y_wide[XY_W-1])
                    begin
                        sum_y_next = sum_y_wide[XY_W] ? {1'b1, {(XY_W-1){1'b0}}}
                                                      : {1'b0, {(XY_W-1){1'b1}}};
                    end
                    else
                    begin
                        sum_y_next = sum_y_wide[XY_W-1:0];
                    end
                    if (used_reg < COUNT_W'(COUNT_CAP))
                    begin
                        used_next = used_reg + 1'b1;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (last_reg)
                begin
                    done_next     = 1'b1;
                    drive_x_next  = sum_x_reg;
                    drive_y_next  = sum_y_reg;
                    nused_next    = used_reg;
                    coin_out_next = coin_reg;
                    sum_x_next    = '0;
                    sum_y_next    = '0;
                    used_next     = '0;
                    coin_next     = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            used_reg  <= '0;
            coin_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            used_reg  <= used_next;
            coin_reg  <= coin_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        id_hit_reg   <= id_hit_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        negx_reg     <= negx_next;
        negy_reg     <= negy_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        sq_reg       <= sq_next;
        root_reg     <= root_next;
        rrem_reg     <= rrem_next;
        drive_x_reg  <= drive_x_next;
        drive_y_reg  <= drive_y_next;
        nused_reg    <= nused_next;
        coin_out_reg <= coin_out_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign drive_x         = drive_x_reg;
    assign drive_y         = drive_y_reg;
    assign neighbors_used  = nused_reg;
    assign coincident_seen = coin_out_reg;

    // A result only follows the closing step of an item.
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FIN))
        else $error("result strobe without a finished item");

    // Both component dividers run in lock step on the same distance.
    a_comp_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        cx_done == cy_done)
        else $error("component dividers out of step");

    // Dividers only report back while the sequencer waits for them.
    a_comp_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cx_done |-> (state_reg == ST_DIV))
        else $error("divider result outside the divide phase");

    // The root remainder never exceeds twice the root.
    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RANGE) |-> (rrem_reg <= ROOT_REM_W'({root_reg, 1'b0})))
        else $error("square root remainder out of bounds");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= COUNT_W'(COUNT_CAP))
        else $error("neighbor count above its cap");

endmodule
